FILE: hdl/rational_arithmetic_unit_assert.svh
// Assertion macros for the checker file of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/rau_pkg.sv
// Types and codes shared by the rational arithmetic unit modules.
`default_nettype none
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_REDUCE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA,
    S_MB,
    S_MC,
    S_MD,
    S_FORM,
    S_GCD,
    S_DIVN,
    S_DIVD
  } state_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_CHK,
    G_TWO,
    G_AODD,
    G_LOOP
  } gcd_state_t;

  localparam int MAG_BITS = 64;
  localparam int SH_BITS  = 6;

endpackage
`default_nettype wire

FILE: hdl/rau_gcd.sv
// Binary GCD of two 64-bit magnitudes, one shift or compare-subtract per cycle.
`default_nettype none
module rau_gcd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a_in,
  input  wire logic [63:0] b_in,
  output logic             done,
  output logic [63:0]      gcd
);
  import rau_pkg::*;

  gcd_state_t           state_r, state_nxt;
  logic [63:0]          a_r, a_nxt, b_r, b_nxt;
  logic [SH_BITS-1:0]   sh_r, sh_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_IDLE: if (start) state_nxt = G_CHK;
      G_CHK: begin
        if (a_r == '0 || b_r == '0) state_nxt = G_LOOP;
        else state_nxt = G_TWO;
      end
      G_TWO:  if (a_r[0] | b_r[0]) state_nxt = G_AODD;
      G_AODD: if (a_r[0]) state_nxt = G_LOOP;
      G_LOOP: if (b_r == '0) state_nxt = G_IDLE;
      default: state_nxt = G_IDLE;
    endcase
  end

  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    sh_nxt = sh_r;
    done   = 1'b0;
    gcd    = a_r << sh_r;
    case (state_r)
      G_IDLE: begin
        if (start) begin
          a_nxt  = a_in;
          b_nxt  = b_in;
          sh_nxt = '0;
        end
      end
      G_CHK: begin
        // A zero operand makes the other one the answer.
        if (a_r == '0) begin
          a_nxt = b_r;
          b_nxt = '0;
        end
      end
      G_TWO: begin
        if (!(a_r[0] | b_r[0])) begin
          a_nxt  = a_r >> 1;
          b_nxt  = b_r >> 1;
          sh_nxt = sh_r + 1'b1;
        end
      end
      G_AODD: if (!a_r[0]) a_nxt = a_r >> 1;
      G_LOOP: begin
        if (b_r == '0) begin
          done = 1'b1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = b_r;
          b_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= G_IDLE;
    else state_r <= state_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    sh_r <= sh_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/rau_div.sv
// Restoring divider for 64-bit magnitudes, one quotient bit per cycle.
`default_nettype none
module rau_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  import rau_pkg::*;

  logic              busy_r, done_r;
  logic [5:0]        cnt_r;
  logic [64:0]       rem_r;
  logic [63:0]       dvd_r, dvs_r;
  logic [64:0]       trial;
  logic              fits;

  assign trial    = {rem_r[63:0], dvd_r[63]};
  assign fits     = trial >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'(MAG_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // The dividend register fills with quotient bits from the bottom.
      rem_r <= fits ? trial - {1'b0, dvs_r} : trial;
      dvd_r <= {dvd_r[62:0], fits};
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier and result registers.
//
// One command is taken when start is high and busy is low; busy then stays high until the
// result word is shown, and falls in the same cycle that out_valid rises. The result stands
// on the out_ ports for a single cycle with out_valid high, and the receiver cannot stall it.
// A command runs through the products on the shared 32x32 multiplier (S_MA to S_MD), the
// forming of the raw fraction, the binary GCD loop with one shift or compare-subtract per
// cycle, and two 64-step restoring divisions by the GCD. A zero raw denominator skips the
// GCD and divisions and answers from the forming step with status ST_ZERO_DEN.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [31:0] in_left_num,
  input  wire logic signed [31:0] in_left_den,
  input  wire logic signed [31:0] in_right_num,
  input  wire logic signed [31:0] in_right_den,
  output logic                    out_valid,
  output logic signed [31:0]      out_result_num,
  output logic [30:0]             out_result_den,
  output logic                    out_left_less,
  output logic                    out_operands_equal,
  output rau_pkg::status_t        out_status
);
  import rau_pkg::*;

  localparam logic [63:0] LIM = 64'(1) << (VALUE_BITS - 1);

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic signed [31:0]  ln_r, ld_r, rn_r, rd_r;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  mul_p;
  logic signed [63:0]  pa_r, pb_r, pd_r, pm_r;
  logic signed [64:0]  num_s;
  logic [63:0]         nmag, dmag;
  logic [63:0]         nmag_r, dmag_r, g_r, nq_r;
  logic                sign_r, less_r, eq_r;
  logic                gcd_start, gcd_done;
  logic [63:0]         gcd_g;
  logic                div_start, div_done;
  logic [63:0]         div_dvd, div_dvs, div_q;
  logic                neg, ovf;

  assign busy  = state_r != S_IDLE;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_MA;
      S_MA:    state_nxt = S_MB;
      S_MB:    state_nxt = S_MC;
      S_MC:    state_nxt = S_MD;
      S_MD:    state_nxt = S_FORM;
      S_FORM:  state_nxt = (dmag == '0) ? S_IDLE : S_GCD;
      S_GCD:   if (gcd_done) state_nxt = S_DIVN;
      S_DIVN:  if (div_done) state_nxt = S_DIVD;
      S_DIVD:  if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and start pulses for the units.
  always_comb begin
    mul_a     = ln_r;
    mul_b     = rd_r;
    gcd_start = 1'b0;
    div_start = 1'b0;
    div_dvd   = dmag_r;
    div_dvs   = g_r;
    case (state_r)
      S_MB: begin
        mul_a = rn_r;
        mul_b = ld_r;
      end
      S_MC: begin
        mul_a = ld_r;
        case (cmd_r)
          CMD_ADD, CMD_SUB, CMD_MUL: mul_b = rd_r;
          CMD_DIV: mul_b = rn_r;
          default: mul_b = 32'sd1;
        endcase
      end
      S_MD: begin
        mul_a = ln_r;
        mul_b = rn_r;
      end
      S_FORM: gcd_start = dmag != '0;
      S_GCD: begin
        div_start = gcd_done;
        div_dvd   = nmag_r;
        div_dvs   = gcd_g;
      end
      S_DIVN: div_start = div_done;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_r)
      CMD_ADD: num_s = 65'(pa_r) + 65'(pb_r);
      CMD_SUB: num_s = 65'(pa_r) - 65'(pb_r);
      CMD_MUL: num_s = 65'(pm_r);
      CMD_DIV: num_s = 65'(pa_r);
      default: num_s = 65'(ln_r);
    endcase
    nmag = num_s[64] ? 64'(-num_s) : num_s[63:0];
    dmag = pd_r[63] ? 64'(-pd_r) : 64'(pd_r);
    neg  = sign_r && (nq_r != '0);
    ovf  = (div_q > LIM - 64'd1) || (neg ? nq_r > LIM : nq_r > LIM - 64'd1);
  end

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (nmag),
    .b_in  (dmag),
    .done  (gcd_done),
    .gcd   (gcd_g)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_FORM && dmag == '0) || (state_r == S_DIVD && div_done);
    end
    if (state_r == S_IDLE && start) begin
      cmd_r <= cmd_t'(in_command);
      ln_r  <= in_left_num;
      ld_r  <= in_left_den;
      rn_r  <= in_right_num;
      rd_r  <= in_right_den;
    end
    case (state_r)
      S_MA: pa_r <= mul_p;
      S_MB: pb_r <= mul_p;
      S_MC: pd_r <= mul_p;
      S_MD: pm_r <= mul_p;
      S_FORM: begin
        nmag_r <= nmag;
        dmag_r <= dmag;
        sign_r <= num_s[64] ^ pd_r[63];
        less_r <= pa_r < pb_r;
        eq_r   <= (ln_r == rn_r) && (ld_r == rd_r);
        if (dmag == '0) begin
          out_result_num     <= '0;
          out_result_den     <= '0;
          out_left_less      <= pa_r < pb_r;
          out_operands_equal <= (ln_r == rn_r) && (ld_r == rd_r);
          out_status         <= ST_ZERO_DEN;
        end
      end
      S_GCD: if (gcd_done) g_r <= gcd_g;
      S_DIVN: if (div_done) nq_r <= div_q;
      S_DIVD: begin
        if (div_done) begin
          out_left_less      <= less_r;
          out_operands_equal <= eq_r;
          if (ovf) begin
            out_result_num <= '0;
            out_result_den <= '0;
            out_status     <= ST_OVERFLOW;
          end else begin
            out_result_num <= neg ? -$signed(nq_r[31:0]) : $signed(nq_r[31:0]);
            out_result_den <= div_q[30:0];
            out_status     <= ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind statement.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rau_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [30:0]      out_result_den,
  input wire rau_pkg::status_t out_status
);
  import rau_pkg::*;

  // A taken command always keeps the unit busy on the next cycle.
  `RAU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  // A result word only ends a command that was in progress.
  `RAU_ASSERT_NOW(a_valid_after_busy, clk, rst_n, out_valid, $past(busy))
  // Results never come in consecutive cycles.
  `RAU_ASSERT_NEXT(a_valid_single, clk, rst_n, out_valid, !out_valid)
  // A good result has a nonzero denominator, an error result a zero one.
  `RAU_ASSERT_NOW(a_den_status, clk, rst_n, out_valid,
                  (out_status == ST_OK) == (out_result_den != '0))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire
